@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
// Uses clk and arst_n of the including module; compiled out under SYNTH.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define IRPK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define IRPK_NEVER(lbl, expr, msg) `IRPK_ASSERT(lbl, !(expr), msg)
`else
`define IRPK_ASSERT(lbl, prop, msg)
`define IRPK_NEVER(lbl, expr, msg)
`endif
`endif

@@ rtl/irpk_pkg.sv @@
// Types, constants and codes for the pulse to symbol packer.
// No dependencies; used by irpk_alu and the top level.
package irpk_pkg;

	localparam int DUR_W  = 21;     // microsecond durations and gaps
	localparam int HALF_W = 15;     // one half of a symbol word
	localparam int MAG_W  = 7;      // pulse length magnitude in ticks
	localparam int TICK_W = 14;
	localparam int CNT_W  = 6;      // words per item, 0..WORDS_MAX

	localparam logic [HALF_W-1:0] MAX_CHUNK_US = HALF_W'(32767);
	localparam logic [CNT_W-1:0]  WORDS_MAX    = CNT_W'(32);

	// configuration register indexes
	localparam logic CFG_GAP_DEFAULT  = 1'b0;
	localparam logic CFG_GAP_OVERRIDE = 1'b1;
	localparam logic [DUR_W-1:0] GAP_DEFAULT_RST = DUR_W'(40000);

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_EMPTY   = 2'd2
	} status_t;

	typedef enum logic {
		ALU_MAC,
		ALU_CHUNK
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [DUR_W-1:0] a;
		logic [DUR_W-1:0] b;
		logic             b_en;
	} alu_req_t;

	typedef struct packed {
		logic [DUR_W-1:0]  sum;
		logic [HALF_W-1:0] chunk;
	} alu_rsp_t;

	typedef struct packed {
		status_t           status;
		logic              last;
		logic [HALF_W-1:0] duration_b;
		logic              level_b;
		logic [HALF_W-1:0] duration_a;
		logic              level_a;
	} word_t;

endpackage

@@ rtl/irpk_alu.sv @@
// Shared 21-bit adder unit: shift-add multiply step and chunk cut.
// Depends on irpk_pkg.
module irpk_alu (
	input  irpk_pkg::alu_req_t req,
	output irpk_pkg::alu_rsp_t rsp
);

	logic                          gt;
	logic [irpk_pkg::HALF_W-1:0]   chunk;
	logic [irpk_pkg::DUR_W-1:0]    addend;
	logic                          cin;

	assign gt    = req.a > irpk_pkg::DUR_W'(irpk_pkg::MAX_CHUNK_US);
	assign chunk = gt ? irpk_pkg::MAX_CHUNK_US : req.a[irpk_pkg::HALF_W-1:0];

	// one adder: a + b (b gated by b_en) for multiply steps, a - chunk via inverted operand and carry-in
	always_comb begin
		case (req.op)
			irpk_pkg::ALU_MAC: begin
				addend = req.b_en ? req.b : '0;
				cin    = 1'b0;
			end
			irpk_pkg::ALU_CHUNK: begin
				addend = ~irpk_pkg::DUR_W'(chunk);
				cin    = 1'b1;
			end
			default: begin
				addend = '0;
				cin    = 1'b0;
			end
		endcase
	end

	assign rsp.sum   = req.a + addend + irpk_pkg::DUR_W'(cin);
	assign rsp.chunk = chunk;

endmodule

@@ rtl/ir_pulse_to_symbol_packer_top.sv @@
// Top level of the mark/space pulse to symbol word packer.
// Depends on irpk_pkg, irpk_alu and assert_macros.svh.
//
// channel  dir  transaction            payload
// s_*      in   pulse or end item      tdata: pulse_units, tick_us, suggested_gap_us
//                                      tuser: mode, frame_start
// m_*      out  symbol word            tdata: level_a, duration_a, level_b, duration_b
//                                      tuser: status, tlast: last
// cfg_*    in   register write         cfg_addr index, cfg_wdata value
//
// Pulse item: accept, shift-add steps in S_MUL, then 1 cycle per chunk (up to 64)
// in S_CHUNK; end item: accept, chunks (up to 64), then S_FLUSH. Multiply and chunk
// arithmetic uses the one 21-bit adder in irpk_alu. s_tready is high only when idle.
// Steps that load the output register wait while it is full and not taken.
// Reset is asynchronous and immediate; no clearing pass.
`include "assert_macros.svh"
module ir_pulse_to_symbol_packer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // pulse_units[7:0], tick_us[21:8], suggested_gap_us[42:22]
	input  logic [1:0]  s_tuser,   // mode[0], frame_start[1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // level_a[0], duration_a[15:1], level_b[16], duration_b[31:17]
	output logic [1:0]  m_tuser,   // status[1:0]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [20:0] cfg_wdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_CHUNK,
		S_FLUSH,
		S_ERR
	} state_t;

	state_t                        state_q;
	logic [irpk_pkg::DUR_W-1:0]    rem_q;
	logic [irpk_pkg::DUR_W-1:0]    mcand_q;
	logic [irpk_pkg::MAG_W-1:0]    mplier_q;
	logic                          level_q;
	logic                          is_end_q;
	logic [irpk_pkg::CNT_W-1:0]    n_q;
	logic                          half_valid_q;
	logic                          half_level_q;
	logic [irpk_pkg::HALF_W-1:0]   half_dur_q;
	logic                          any_q;
	logic [irpk_pkg::DUR_W-1:0]    gap_default_q;
	logic                          gap_override_q;
	logic                          out_valid_q;
	irpk_pkg::word_t               out_word_q;

	logic [7:0]                    in_units;
	logic [irpk_pkg::TICK_W-1:0]   in_tick;
	logic [irpk_pkg::DUR_W-1:0]    in_gap;
	logic                          in_mode;
	logic                          in_fstart;
	logic [7:0]                    in_abs;
	logic                          in_bad;
	logic [irpk_pkg::DUR_W-1:0]    gap_sel;
	logic                          can_put;
	logic                          n_full;
	logic                          chunk_last;
	logic                          word_load;
	irpk_pkg::alu_req_t            alu_req;
	irpk_pkg::alu_rsp_t            alu_rsp;

	assign in_units  = s_tdata[7:0];
	assign in_tick   = s_tdata[21:8];
	assign in_gap    = s_tdata[42:22];
	assign in_mode   = s_tuser[0];
	assign in_fstart = s_tuser[1];
	assign in_abs    = in_units[7] ? (~in_units + 8'd1) : in_units;

	// zero, -128, zero tick, or a frame that does not open with a mark
	assign in_bad = (in_units == 8'h00) || (in_units == 8'h80) || (in_tick == '0)
		|| (in_fstart && in_units[7]);

	assign gap_sel = gap_override_q ? gap_default_q
		: ((in_gap != '0) ? in_gap : gap_default_q);

	assign can_put    = !out_valid_q || m_tready;
	assign n_full     = (n_q == irpk_pkg::WORDS_MAX);
	// a gap word is final when the gap is used up or the word limit is hit
	assign chunk_last = is_end_q && ((alu_rsp.sum == '0)
		|| (n_q == irpk_pkg::WORDS_MAX - irpk_pkg::CNT_W'(1)));

	// output register loads: a paired chunk, a flush or terminator word, or an error word
	always_comb begin
		case (state_q)
			S_CHUNK: word_load = can_put && (rem_q != '0) && half_valid_q && !n_full;
			S_FLUSH: word_load = can_put && (half_valid_q ? !n_full : (n_q == '0));
			S_ERR:   word_load = can_put;
			default: word_load = 1'b0;
		endcase
	end

	assign alu_req.op   = (state_q == S_MUL) ? irpk_pkg::ALU_MAC : irpk_pkg::ALU_CHUNK;
	assign alu_req.a    = rem_q;
	assign alu_req.b    = mcand_q;
	assign alu_req.b_en = mplier_q[0];

	irpk_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_word_q.duration_b, out_word_q.level_b,
		out_word_q.duration_a, out_word_q.level_a};
	assign m_tuser  = out_word_q.status;
	assign m_tlast  = out_word_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			rem_q          <= '0;
			mcand_q        <= '0;
			mplier_q       <= '0;
			level_q        <= 1'b0;
			is_end_q       <= 1'b0;
			n_q            <= '0;
			half_valid_q   <= 1'b0;
			half_level_q   <= 1'b0;
			half_dur_q     <= '0;
			any_q          <= 1'b0;
			gap_default_q  <= irpk_pkg::GAP_DEFAULT_RST;
			gap_override_q <= 1'b0;
			out_valid_q    <= 1'b0;
			out_word_q     <= '0;
		end else begin
			if (word_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_addr)
					irpk_pkg::CFG_GAP_DEFAULT:  gap_default_q  <= cfg_wdata;
					irpk_pkg::CFG_GAP_OVERRIDE: gap_override_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						n_q <= '0;
						if (in_mode) begin
							rem_q    <= gap_sel;
							level_q  <= 1'b0;
							is_end_q <= 1'b1;
							state_q  <= S_CHUNK;
						end else if (in_bad) begin
							state_q <= S_ERR;
						end else begin
							rem_q    <= '0;
							mcand_q  <= irpk_pkg::DUR_W'(in_tick);
							mplier_q <= in_abs[irpk_pkg::MAG_W-1:0];
							level_q  <= ~in_units[7];
							is_end_q <= 1'b0;
							state_q  <= S_MUL;
						end
					end
				end
				S_MUL: begin
					rem_q    <= alu_rsp.sum;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					if (mplier_q[irpk_pkg::MAG_W-1:1] == '0) begin
						state_q <= S_CHUNK;
					end
				end
				S_CHUNK: begin
					if (rem_q == '0) begin
						state_q <= is_end_q ? S_FLUSH : S_IDLE;
					end else if (half_valid_q) begin
						if (n_full) begin
							// word past the limit is dropped, half still consumed
							half_valid_q <= 1'b0;
							any_q        <= 1'b1;
							rem_q        <= alu_rsp.sum;
						end else if (can_put) begin
							out_word_q.level_a    <= half_level_q;
							out_word_q.duration_a <= half_dur_q;
							out_word_q.level_b    <= level_q;
							out_word_q.duration_b <= alu_rsp.chunk;
							out_word_q.last       <= chunk_last;
							out_word_q.status     <= irpk_pkg::ST_OK;
							n_q                   <= n_q + irpk_pkg::CNT_W'(1);
							half_valid_q          <= 1'b0;
							any_q                 <= 1'b1;
							rem_q                 <= alu_rsp.sum;
						end
					end else if (n_full) begin
						state_q <= is_end_q ? S_FLUSH : S_IDLE;
					end else begin
						half_valid_q <= 1'b1;
						half_level_q <= level_q;
						half_dur_q   <= alu_rsp.chunk;
						any_q        <= 1'b1;
						rem_q        <= alu_rsp.sum;
					end
				end
				S_FLUSH: begin
					if (half_valid_q && !n_full) begin
						if (can_put) begin
							out_word_q.level_a    <= half_level_q;
							out_word_q.duration_a <= half_dur_q;
							out_word_q.level_b    <= 1'b0;
							out_word_q.duration_b <= '0;
							out_word_q.last       <= 1'b1;
							out_word_q.status     <= irpk_pkg::ST_OK;
							half_valid_q          <= 1'b0;
							any_q                 <= 1'b0;
							state_q               <= S_IDLE;
						end
					end else if (!half_valid_q && (n_q == '0)) begin
						// nothing completed: bare terminator
						if (can_put) begin
							out_word_q.level_a    <= 1'b0;
							out_word_q.duration_a <= '0;
							out_word_q.level_b    <= 1'b0;
							out_word_q.duration_b <= '0;
							out_word_q.last       <= 1'b1;
							out_word_q.status     <= any_q ? irpk_pkg::ST_OK
								: irpk_pkg::ST_EMPTY;
							any_q                 <= 1'b0;
							state_q               <= S_IDLE;
						end
					end else begin
						half_valid_q <= 1'b0;
						any_q        <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				S_ERR: begin
					if (can_put) begin
						out_word_q.level_a    <= 1'b0;
						out_word_q.duration_a <= '0;
						out_word_q.level_b    <= 1'b0;
						out_word_q.duration_b <= '0;
						out_word_q.last       <= 1'b0;
						out_word_q.status     <= irpk_pkg::ST_INVALID;
						state_q               <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`IRPK_NEVER(a_word_count, n_q > irpk_pkg::WORDS_MAX, "word count past limit")
	`IRPK_ASSERT(a_empty_is_last, m_tvalid && (m_tuser == irpk_pkg::ST_EMPTY) |-> m_tlast, "empty word without last")
	`IRPK_ASSERT(a_invalid_word, m_tvalid && (m_tuser == irpk_pkg::ST_INVALID) |-> !m_tlast && (m_tdata == '0), "bad invalid word")
	`IRPK_ASSERT(a_flush_clears, (state_q == S_IDLE) && ($past(state_q) == S_FLUSH) |-> !half_valid_q && !any_q, "state left after end item")
	`IRPK_ASSERT(a_mul_nonzero, (state_q == S_CHUNK) && ($past(state_q) == S_MUL) |-> (rem_q != '0), "zero product from valid pulse")

endmodule
